// ===== hw/rtl/cdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque package
// Shared types, operation and status codes, and the default store depth.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int CDQ_DEPTH = 128;
  localparam int CDQ_WORD_W = 32;
  localparam int CDQ_COUNT_W = 8;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } cdq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  typedef struct packed {
    cdq_op_t                       opcode;
    logic signed [CDQ_WORD_W-1:0]  value;
  } cdq_in_t;

  typedef struct packed {
    cdq_status_t                   status;
    logic signed [CDQ_WORD_W-1:0]  data;
    logic [CDQ_COUNT_W-1:0]        count;
  } cdq_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic data_ram;
  } cdq_cmd_t;

  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
  } cdq_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/circular_deque_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque core
// A double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries. An item is taken when start is high and busy is low. Its result
// appears for one cycle with done high, after the state S_EXEC for a push
// or a failed operation and after S_EXEC and S_POPRD for a successful pop,
// and busy is already low in that cycle, so a new item can be taken then;
// busy keeps further items off while one is in progress. S_POPRD of a pop
// is the registered read of the store memory. Results cannot be held off:
// sample them when done is high. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cdq_in_t cmd,
  output logic         busy,
  output logic         done,
  output cdq_out_t     result
);

  cdq_cmd_t  ctl;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (ctl),
    .busy  (busy),
    .done  (done)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .cmd    (ctl),
    .stat   (stat),
    .result (result)
  );

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobed while an item is still in progress.");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the core busy.");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobed without an item in progress.");

  a_full_empty : assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("Store reported both full and empty.");

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences accept, execute and the store read of a pop, and strobes results.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire cdq_stat_t stat,
  output cdq_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_POPRD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;
  logic   pop_ok;

  assign pop_ok = !stat.is_push && !stat.empty;

  always_comb begin
    state_next   = state;
    done_next    = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (pop_ok) begin
          state_next = S_POPRD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POPRD: begin
        cmd.data_ram = 1'b1;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque datapath
// Holds the item, the head and tail indices, the element count, the store
// and the result register.
// ----------------------------------------------------------------------------
module cdq_dpath
  import cdq_pkg::*;
#(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cdq_in_t  cmd_in,
  input  wire cdq_cmd_t cmd,
  output cdq_stat_t     stat,
  output cdq_out_t      result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cdq_in_t                item;
  logic [IW-1:0]          head;
  logic [IW-1:0]          tail;
  logic [CW-1:0]          cnt;
  logic [IW-1:0]          head_next;
  logic [IW-1:0]          tail_next;
  logic [CW-1:0]          cnt_next;
  logic [IW-1:0]          ram_addr;
  logic                   ram_we;
  logic [CDQ_WORD_W-1:0]  ram_rdata;
  logic [CW+CDQ_COUNT_W-1:0] cnt_ext;
  cdq_status_t            status_next;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    idx_inc = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    idx_dec = (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign stat.is_push = !item.opcode[1];
  assign stat.full    = (cnt == CW'(DEPTH));
  assign stat.empty   = (cnt == '0);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    cnt_next    = cnt;
    ram_addr    = '0;
    ram_we      = 1'b0;
    status_next = ST_DONE;
    if (stat.is_push) begin
      if (stat.full) begin
        status_next = ST_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
        ram_we   = cmd.exec;
        if (stat.empty) begin
          head_next = '0;
          tail_next = '0;
          ram_addr  = '0;
        end else if (item.opcode == OP_PUSH_BACK) begin
          tail_next = idx_inc(tail);
          ram_addr  = idx_inc(tail);
        end else begin
          head_next = idx_dec(head);
          ram_addr  = idx_dec(head);
        end
      end
    end else begin
      if (stat.empty) begin
        status_next = ST_EMPTY;
      end else begin
        cnt_next = cnt - 1'b1;
        ram_addr = (item.opcode == OP_POP_FRONT) ? head : tail;
        if (cnt == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else if (item.opcode == OP_POP_FRONT) begin
          head_next = idx_inc(head);
        end else begin
          tail_next = idx_dec(tail);
        end
      end
    end
  end

  assign cnt_ext = {{CDQ_COUNT_W{1'b0}}, cnt_next};

  cdq_ram #(
    .WIDTH (CDQ_WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item.value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= cmd_in;
    end
    if (cmd.exec) begin
      result.status <= status_next;
      result.count  <= cnt_ext[CDQ_COUNT_W-1:0];
      result.data   <= '0;
    end else if (cmd.data_ram) begin
      result.data <= ram_rdata;
    end
  end

endmodule
`default_nettype wire
